// ===== sv/cpspc_pkg.sv =====
package cpspc_pkg;

    // Word layout: two bits per input variable, odd bit of each pair is the "10" half
    localparam int WORD_BITS = 32;
    localparam int MAX_WORDS_DEF = 64;
    localparam logic [WORD_BITS-1:0] ODD_MASK = {(WORD_BITS/2){2'b10}};

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 7;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_INPUT_WORDS = 2'd0,
        CFG_MERGE_WORD  = 2'd1,
        CFG_MERGE_VAR   = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        REL_NEITHER  = 2'd0,
        REL_EQUAL    = 2'd1,
        REL_A_COVERS = 2'd2,
        REL_B_COVERS = 2'd3
    } relation_t;

    typedef struct packed {
        logic [31:0] word_a;
        logic [31:0] word_b;
        logic        last;
    } in_item_t;

    typedef struct packed {
        logic [31:0] star_word;
        logic        last_out;
        logic        star_ok;
        logic        intersects;
        logic [1:0]  relation;
    } out_item_t;

endpackage

// ===== sv/cube_pair_star_product_compare_top.sv =====
// Star product and containment of two cubes in positional notation.
//
// Channels: s_valid/s_ready/s_data carry one word pair of cubes A and B per
// transfer, with s_data.last on the final word. m_valid/m_ready/m_data
// return one result per input word: the star-product word, a copy of last,
// and, on the last word only, star_ok, intersects and relation. On every
// other word those three summary fields read zero.
// cfg_valid/cfg_ready/cfg_addr/cfg_data write the registers: address 0 is
// input_words, 1 is merge_word, 2 is merge_var; address 3 is ignored.
// cfg_ready is always high. Write only while no cube is in flight.
//
// The result of a transfer is presented in the cycle after it is accepted.
// Throughput is one word per cycle while m_ready stays high; the only state
// on the path is the output register, so s_ready is high whenever that
// register is empty or being drained in the same cycle.
//
// Reset (aresetn low, synchronous) empties the output register, sets the
// registers to input_words 1, merge_word 0, merge_var 0, clears the per-cube
// index and flags and sets both cover flags. When the receiver stalls, the
// result holds in the output register and s_ready drops until it is taken.
module cube_pair_star_product_compare_top #(
    parameter int MAX_WORDS = cpspc_pkg::MAX_WORDS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  cpspc_pkg::in_item_t                 s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output cpspc_pkg::out_item_t                m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [cpspc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [cpspc_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import cpspc_pkg::*;

    localparam int IDX_W = $clog2(MAX_WORDS + 1);
    localparam int CMP_W = (IDX_W > 7) ? IDX_W : 7;

    // Configuration registers
    logic [6:0] input_words_reg;
    logic [5:0] merge_word_reg;
    logic [3:0] merge_var_reg;

    // Per-cube state
    logic [IDX_W-1:0] word_index_reg, word_index_next;
    logic             star_failed_reg, star_failed_next;
    logic             empty_var_reg, empty_var_next;
    logic             common_out_reg, common_out_next;
    logic             a_covers_b_reg, a_covers_b_next;
    logic             b_covers_a_reg, b_covers_a_next;

    // Output register
    logic      m_valid_reg;
    out_item_t m_data_reg, m_data_next;

    logic s_fire;

    // Datapath signals
    logic [WORD_BITS-1:0] prod;
    logic [WORD_BITS-1:0] live;
    logic [WORD_BITS-1:0] var10;
    logic [WORD_BITS-1:0] var11;
    logic                 is_input_word;
    logic                 at_merge_word;
    logic                 word_empty;
    logic                 word_fail;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign s_fire    = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // Take a register write whenever it is offered
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            input_words_reg <= 7'd1;
            merge_word_reg  <= 6'd0;
            merge_var_reg   <= 4'd0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_addr)
                CFG_INPUT_WORDS: input_words_reg <= cfg_data;
                CFG_MERGE_WORD:  merge_word_reg  <= cfg_data[5:0];
                CFG_MERGE_VAR:   merge_var_reg   <= cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    // Word classification: input-variable words precede output words
    assign prod          = s_data.word_a & s_data.word_b;
    assign is_input_word = CMP_W'(word_index_reg) < CMP_W'(input_words_reg);
    assign at_merge_word = CMP_W'(word_index_reg) == CMP_W'(merge_word_reg);

    // A pair is live if either of its bits survives the AND
    assign live  = ((prod << 1) | prod) & ODD_MASK;
    assign var10 = WORD_BITS'(2) << {merge_var_reg, 1'b0};
    assign var11 = WORD_BITS'(3) << {merge_var_reg, 1'b0};

    // An empty pair is only acceptable when it is the merge variable alone
    assign word_empty = is_input_word && (live != ODD_MASK);
    assign word_fail  = word_empty && (((live | var10) != ODD_MASK) || !at_merge_word);

    always_comb begin
        star_failed_next = star_failed_reg || word_fail;
        empty_var_next   = empty_var_reg || word_empty;
        common_out_next  = common_out_reg || (!is_input_word && (prod != '0));
        a_covers_b_next  = a_covers_b_reg && (prod == s_data.word_b);
        b_covers_a_next  = b_covers_a_reg && (prod == s_data.word_a);
        word_index_next  = word_index_reg;
        if (word_index_reg < IDX_W'(MAX_WORDS)) begin
            word_index_next = word_index_reg + 1'b1;
        end

        m_data_next           = '0;
        m_data_next.star_word = (word_empty && !word_fail) ? (prod | var11) : prod;
        m_data_next.last_out  = s_data.last;
        if (s_data.last) begin
            m_data_next.star_ok    = !star_failed_next && common_out_next;
            m_data_next.intersects = !empty_var_next && common_out_next;
            if (a_covers_b_next && b_covers_a_next) begin
                m_data_next.relation = REL_EQUAL;
            end else if (a_covers_b_next) begin
                m_data_next.relation = REL_A_COVERS;
            end else if (b_covers_a_next) begin
                m_data_next.relation = REL_B_COVERS;
            end else begin
                m_data_next.relation = REL_NEITHER;
            end
        end
    end

    // Advance the cube state on every transfer; drop it back after the last word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_index_reg  <= '0;
            star_failed_reg <= 1'b0;
            empty_var_reg   <= 1'b0;
            common_out_reg  <= 1'b0;
            a_covers_b_reg  <= 1'b1;
            b_covers_a_reg  <= 1'b1;
        end else if (s_fire) begin
            if (s_data.last) begin
                word_index_reg  <= '0;
                star_failed_reg <= 1'b0;
                empty_var_reg   <= 1'b0;
                common_out_reg  <= 1'b0;
                a_covers_b_reg  <= 1'b1;
                b_covers_a_reg  <= 1'b1;
            end else begin
                word_index_reg  <= word_index_next;
                star_failed_reg <= star_failed_next;
                empty_var_reg   <= empty_var_next;
                common_out_reg  <= common_out_next;
                a_covers_b_reg  <= a_covers_b_next;
                b_covers_a_reg  <= b_covers_a_next;
            end
        end
    end

    // Output register: load on transfer in, empty when taken with nothing behind it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            m_data_reg <= m_data_next;
        end
    end

    a_summary_only_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_data_reg.last_out) |->
            (!m_data_reg.star_ok && !m_data_reg.intersects && m_data_reg.relation == REL_NEITHER))
        else $error("summary fields set on a word that is not last");

    a_intersect_implies_star: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.intersects) |-> m_data_reg.star_ok)
        else $error("cubes intersect but star product reported missing");

    a_restart_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_data.last) |=>
            (word_index_reg == '0 && a_covers_b_reg && b_covers_a_reg && !common_out_reg))
        else $error("cube state not cleared after last word");

    a_index_saturates: assert property (@(posedge aclk) disable iff (!aresetn)
        word_index_reg <= IDX_W'(MAX_WORDS))
        else $error("word index beyond saturation limit");

endmodule

// ===== tb/cube_star_checker.sv =====
module cube_star_checker
    import cpspc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  in_item_t              s_data,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  out_item_t             m_data,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    outstanding
);

    logic [CFG_DATA_W-1:0] cube_inputs;
    logic [5:0]            merge_word_idx;
    logic [3:0]            merge_var_idx;
    int unsigned           word_pos;
    logic                  star_failed;
    logic                  empty_seen;
    logic                  output_overlap;
    logic                  a_has_b;
    logic                  b_has_a;
    out_item_t             expected_words[$];
    out_item_t             want;
    int                    errors = 0;
    int                    queued = 0;

    assign fail_count  = errors;
    assign outstanding = queued;

    function automatic void clear_cube();
        word_pos       = 0;
        star_failed    = 1'b0;
        empty_seen     = 1'b0;
        output_overlap = 1'b0;
        a_has_b        = 1'b1;
        b_has_a        = 1'b1;
    endfunction

    function automatic out_item_t star_product_step(in_item_t item);
        logic [WORD_BITS-1:0] prod;
        logic [WORD_BITS-1:0] live;
        logic [WORD_BITS-1:0] pair_hi;
        out_item_t            res;
        prod = item.word_a & item.word_b;
        if (word_pos < cube_inputs) begin
            // a pair reading 00 after the AND is an empty variable
            live = ((prod << 1) | prod) & ODD_MASK;
            if (live != ODD_MASK) begin
                pair_hi    = WORD_BITS'(2) << {merge_var_idx, 1'b0};
                empty_seen = 1'b1;
                if ((live | pair_hi) != ODD_MASK || word_pos != merge_word_idx)
                    star_failed = 1'b1;
                else
                    prod = prod | pair_hi | (pair_hi >> 1);
            end
        end else if (prod != '0) begin
            output_overlap = 1'b1;
        end
        if ((item.word_a & item.word_b) != item.word_b)
            a_has_b = 1'b0;
        if ((item.word_a & item.word_b) != item.word_a)
            b_has_a = 1'b0;

        res           = '0;
        res.star_word = prod;
        res.last_out  = item.last;
        if (item.last) begin
            res.star_ok    = !star_failed && output_overlap;
            res.intersects = !empty_seen && output_overlap;
            if (a_has_b && b_has_a)
                res.relation = REL_EQUAL;
            else if (a_has_b)
                res.relation = REL_A_COVERS;
            else if (b_has_a)
                res.relation = REL_B_COVERS;
            else
                res.relation = REL_NEITHER;
            clear_cube();
        end else if (word_pos < MAX_WORDS_DEF) begin
            word_pos++;
        end
        return res;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            cube_inputs    = 7'd1;
            merge_word_idx = '0;
            merge_var_idx  = '0;
            clear_cube();
            expected_words.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_addr)
                    CFG_INPUT_WORDS: cube_inputs    = cfg_data;
                    CFG_MERGE_WORD:  merge_word_idx = cfg_data[5:0];
                    CFG_MERGE_VAR:   merge_var_idx  = cfg_data[3:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                expected_words.push_back(star_product_step(s_data));
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    $error("result transfer with no word pending: %h", m_data);
                    errors++;
                end else begin
                    want = expected_words.pop_front();
                    if (m_data.star_word !== want.star_word) begin
                        $error("star_word: expected %h, got %h",
                               want.star_word, m_data.star_word);
                        errors++;
                    end
                    if (m_data.last_out !== want.last_out) begin
                        $error("last_out: expected %b, got %b",
                               want.last_out, m_data.last_out);
                        errors++;
                    end
                    if (m_data.star_ok !== want.star_ok) begin
                        $error("star_ok: expected %b, got %b",
                               want.star_ok, m_data.star_ok);
                        errors++;
                    end
                    if (m_data.intersects !== want.intersects) begin
                        $error("intersects: expected %b, got %b",
                               want.intersects, m_data.intersects);
                        errors++;
                    end
                    if (m_data.relation !== want.relation) begin
                        $error("relation: expected %0d, got %0d",
                               want.relation, m_data.relation);
                        errors++;
                    end
                end
            end
        end
        queued = expected_words.size();
    end

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
    import cpspc_pkg::*;

    localparam int HALF_PERIOD    = 2;
    localparam int RESET_CYCLES   = 7;
    localparam int STALL_PCT      = 63;
    localparam int BOTH_PCT       = 10;
    localparam int HOLD_CYCLES    = 200;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 4;
    localparam int SAT_INDEX      = MAX_WORDS_DEF;

    // address 3 decodes to nothing; write it anyway to show it is ignored
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE = 2'd3;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    // Shape of a generated cube pair. Containment kinds build B from A so the
    // relation comes out as intended most of the time; NOISE is raw words.
    typedef enum int {
        CUBE_EQUAL,
        CUBE_A_WIDER,
        CUBE_B_WIDER,
        CUBE_MIXED,
        CUBE_ADJACENT,
        CUBE_NOISE
    } cube_kind_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_item_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_item_t             m_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_ADDR_W-1:0] cfg_addr  = CFG_INPUT_WORDS;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    int                    fail_count;
    int                    outstanding;

    idle_mode_t            idle_mode = IDLE_NONE;
    bit                    hold_req  = 1'b0;

    // Stimulus-side copy of the register values, used only to shape cubes
    // (where the input words end, which pair to make adjacent).
    logic [CFG_DATA_W-1:0] cur_inputs = 7'd1;
    logic [5:0]            cur_mword  = '0;
    logic [3:0]            cur_mvar   = '0;

    cube_pair_star_product_compare_top u_top (.*);

    cube_star_checker u_checker (.*);

    initial begin
        forever #HALF_PERIOD aclk = ~aclk;
    end

    // Decide whether this side sits out the current cycle.
    function automatic bit pause_now(idle_mode_t own_mode);
        if (idle_mode == own_mode)
            return $urandom_range(0, 99) < STALL_PCT;
        if (idle_mode == IDLE_BOTH)
            return $urandom_range(0, 99) < BOTH_PCT;
        return 1'b0;
    endfunction

    // Result side: drive m_ready at every falling edge. On a hold request,
    // drop ready for a long stretch so the output register fills and the
    // block has to push back on the sender.
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
            end
            m_ready <= !pause_now(IDLE_RECEIVER);
        end
    end

    // Abort when nothing has moved on any channel for too long.
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // Offer one word pair. Called at a falling edge; returns at the falling
    // edge after the transfer, with valid still high, so back-to-back words
    // never lower and raise valid in the same step.
    task automatic send_word(input logic [WORD_BITS-1:0] a, input logic [WORD_BITS-1:0] b,
                             input logic lst);
        while (pause_now(IDLE_SENDER)) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= in_item_t'{word_a: a, word_b: b, last: lst};
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // Drop valid and wait until every predicted result has come back.
    task automatic settle();
        s_valid <= 1'b0;
        while (outstanding != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    // One register write; valid stays up for the next write of the group.
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_addr  <= addr;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
    endtask

    // Random set of variable pairs forced to don't-care.
    function automatic logic [WORD_BITS-1:0] widen_pairs();
        logic [WORD_BITS-1:0] w;
        w = '0;
        for (int k = 0; k < WORD_BITS / 2; k++)
            if ($urandom_range(0, 3) == 0)
                w[2*k +: 2] = 2'b11;
        return w;
    endfunction

    // Build and send one cube pair under the current register values.
    task automatic send_cube();
        cube_kind_t           kind;
        int                   len;
        int                   adj_word;
        int                   adj_var;
        int                   sel;
        logic [WORD_BITS-1:0] a;
        logic [WORD_BITS-1:0] b;

        sel  = $urandom_range(0, 11);
        kind = (sel == 11) ? CUBE_NOISE : cube_kind_t'(sel % 5);

        // Keep cubes just past the input words; a few run short. With more
        // input words than the index can count, run past saturation.
        if (cur_inputs > SAT_INDEX)
            len = SAT_INDEX + $urandom_range(2, 12);
        else if ($urandom_range(0, 9) == 0)
            len = $urandom_range(1, cur_inputs + 3);
        else
            len = cur_inputs + $urandom_range((cur_inputs == 0) ? 1 : 0, 3);

        // Mostly place the adjacency where merging is allowed, sometimes off it.
        adj_word = ($urandom_range(0, 9) < 7) ? int'(cur_mword) : $urandom_range(0, 3);
        adj_var  = ($urandom_range(0, 9) < 8) ? int'(cur_mvar) : $urandom_range(0, 15);

        for (int i = 0; i < len; i++) begin
            if (kind == CUBE_NOISE) begin
                a = $urandom;
                b = $urandom;
            end else if (((i > SAT_INDEX) ? SAT_INDEX : i) < cur_inputs) begin
                // input word: every pair a literal or don't-care
                for (int k = 0; k < WORD_BITS / 2; k++)
                    a[2*k +: 2] = 2'($urandom_range(1, 3));
                b = a;
                if (kind == CUBE_A_WIDER || kind == CUBE_MIXED)
                    a = a | widen_pairs();
                if (kind == CUBE_B_WIDER || kind == CUBE_MIXED)
                    b = b | widen_pairs();
                if (kind == CUBE_ADJACENT && i == adj_word) begin
                    a[2*adj_var +: 2] = 2'b01;
                    b[2*adj_var +: 2] = 2'b10;
                    // now and then a second opposing pair, which blocks the merge
                    if ($urandom_range(0, 3) == 0) begin
                        sel = $urandom_range(0, 15);
                        a[2*sel +: 2] = 2'b01;
                        b[2*sel +: 2] = 2'b10;
                    end
                end
                // rare empty literal in A
                if ($urandom_range(0, 29) == 0) begin
                    sel = $urandom_range(0, 15);
                    a[2*sel +: 2] = 2'b00;
                end
            end else begin
                // output word
                a = $urandom;
                case (kind)
                    CUBE_EQUAL, CUBE_ADJACENT: b = a;
                    CUBE_A_WIDER:              b = a & $urandom;
                    CUBE_B_WIDER:              b = a | $urandom;
                    default:                   b = $urandom;
                endcase
                if ($urandom_range(0, 7) == 0) begin
                    a = '0;
                    b = '0;
                end
            end
            send_word(a, b, i == len - 1);
        end
    endtask

    // Reprogram all registers while idle, then stream cubes. With squeeze
    // set, ask the result side for a long hold a third of the way through.
    task automatic run_phase(input logic [CFG_DATA_W-1:0] words,
                             input logic [CFG_DATA_W-1:0] mword,
                             input logic [CFG_DATA_W-1:0] mvar,
                             input idle_mode_t mode, input int cubes, input bit squeeze);
        settle();
        write_reg(CFG_INPUT_WORDS, words);
        write_reg(CFG_MERGE_WORD, mword);
        write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
        write_reg(CFG_MERGE_VAR, mvar);
        cfg_valid  <= 1'b0;
        cur_inputs = words;
        cur_mword  = mword[5:0];
        cur_mvar   = mvar[3:0];
        idle_mode  = mode;
        for (int c = 0; c < cubes; c++) begin
            if (squeeze && c == cubes / 3)
                hold_req = 1'b1;
            send_cube();
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed cubes under the reset values: one input word, merge on
        // variable 0 of word 0.
        // single input word, no output word: no common output
        send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        // opposing literals on the merge variable: merge to 11
        send_word(32'hFFFF_FFFD, 32'hFFFF_FFFE, 1'b0);
        send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        // opposing literals on another variable: no merge, star fails
        send_word(32'hFFFF_FFF7, 32'hFFFF_FFFB, 1'b0);
        send_word(32'h0000_0001, 32'h0000_0001, 1'b1);
        // all-zero words: every variable empty, no output overlap
        send_word(32'h0000_0000, 32'h0000_0000, 1'b0);
        send_word(32'h0000_0000, 32'h0000_0000, 1'b1);
        // B covers A, top output bit shared
        send_word(32'h5555_5555, 32'hFFFF_FFFF, 1'b0);
        send_word(32'h8000_0000, 32'hFFFF_FFFF, 1'b1);
        // A covers B over two output words
        send_word(32'hFFFF_FFFF, 32'hAAAA_AAAA, 1'b0);
        send_word(32'hFFFF_FFFF, 32'h0000_0001, 1'b0);
        send_word(32'h0000_0000, 32'h0000_0000, 1'b1);
        // neither covers, disjoint outputs
        send_word(32'h5555_FFFF, 32'hFFFF_5555, 1'b0);
        send_word(32'hFFFF_0000, 32'h0000_FFFF, 1'b1);
        // empty variable away from the merge variable, then outputs shared
        send_word(32'hFFFF_FFF3, 32'hFFFF_FFFF, 1'b0);
        send_word(32'h7FFF_FFFF, 32'hFFFF_FFFE, 1'b1);

        // Random phases. Register extremes: input_words 0, 1, 64 and 127;
        // merge_word 0, 63 and a write with bit 6 set; merge_var 0 and 15,
        // plus writes with high bits that must be dropped.
        run_phase(7'd2,   7'd1,   7'd15,  IDLE_NONE,     90, 1'b1);
        run_phase(7'd1,   7'd0,   7'd7,   IDLE_SENDER,   100, 1'b0);
        run_phase(7'd0,   7'd0,   7'd0,   IDLE_RECEIVER, 60, 1'b0);
        run_phase(7'd4,   7'd3,   7'd0,   IDLE_BOTH,     50, 1'b0);
        run_phase(7'h42,  7'h42,  7'h15,  IDLE_NONE,     3, 1'b0);
        run_phase(7'd3,   7'h42,  7'h15,  IDLE_NONE,     50, 1'b0);
        run_phase(7'd64,  7'd63,  7'd15,  IDLE_SENDER,   3, 1'b0);
        run_phase(7'd127, 7'd127, 7'd127, IDLE_RECEIVER, 2, 1'b0);
        run_phase(7'd2,   7'd40,  7'd9,   IDLE_BOTH,     50, 1'b0);
        run_phase(7'd5,   7'd4,   7'd11,  IDLE_NONE,     10, 1'b0);

        // Drain, let the pipeline run on idle, then report.
        settle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && outstanding == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
